>>> rtl/fltg_pkg.sv
// ----------------------------------------------------------------------------
// fltg_pkg
// Types and constants shared by the tag generator modules.
// ----------------------------------------------------------------------------
package fltg_pkg;

   localparam int unsigned POS_WIDTH  = 12;
   localparam int unsigned HASH_WIDTH = 32;
   localparam int unsigned HEADER_LEN = 4;

   localparam logic [HASH_WIDTH-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_WIDTH-1:0] FNV_PRIME = 32'd16777619;
   localparam logic [HASH_WIDTH-1:0] LCG_MUL   = 32'd1664525;
   localparam logic [HASH_WIDTH-1:0] LCG_ADD   = 32'd1013904223;

   // ascii "DSIG"
   localparam logic [7:0] HEADER_LETTERS [HEADER_LEN] = '{8'h44, 8'h53, 8'h49, 8'h47};

   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_ABSORB  = 2'd1,
      CMD_EMIT    = 2'd2,
      CMD_VERIFY  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] data_byte;
      logic [7:0] check_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]           tag_byte;
      logic [POS_WIDTH-1:0] byte_index;
      logic                 last;
      logic                 mismatch;
      logic                 status;
   } rsp_type;

   function automatic logic [7:0] byte_select(input logic [HASH_WIDTH-1:0] word,
                                              input logic [1:0] sel);
      logic [7:0] res;
      unique case (sel)
         2'd0: res = word[7:0];
         2'd1: res = word[15:8];
         2'd2: res = word[23:16];
         2'd3: res = word[31:24];
         default: res = word[7:0];
      endcase
      return res;
   endfunction

endpackage

>>> rtl/fnv_lcg_tag_generator_unit.sv
// ----------------------------------------------------------------------------
// fnv_lcg_tag_generator_unit
// Builds a tag from an absorbed byte stream with an FNV-1a hash and an LCG.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one request: command, data_byte, check_byte.
//    Restart resets the hash, absorb folds data_byte into the hash, emit
//    produces the next tag byte, verify also compares it with check_byte.
//  - rsp_ channel returns exactly one response per request, in order.
//  - a request is taken into an input register, then the hash update and
//    tag byte selection run from it into the response register, which
//    drives the rsp_ outputs once rsp_stall lets it advance.
//  - one request per cycle sustained while rsp_stall is low; the 32-bit
//    constant multiply and add on the hash register sets the cycle time.
//  - when rsp_stall is high the response holds; one more request is still
//    taken into the input register, then req_stall rises until the
//    response drains.
//  - reset clears both valid flags, returns the hash to the offset basis
//    and clears the tag position and mismatch flag.
// ----------------------------------------------------------------------------
module fnv_lcg_tag_generator_unit #(
   parameter int unsigned TAG_BYTES = 2420
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic [7:0]                     req_data_byte,
   input  logic [7:0]                     req_check_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_tag_byte,
   output logic [fltg_pkg::POS_WIDTH-1:0] rsp_byte_index,
   output logic                           rsp_last,
   output logic                           rsp_mismatch,
   output logic                           rsp_status
);
   import fltg_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type eng_rsp;
   logic    advance;
   logic    fire;
   logic    take;

   assign advance = !out_valid_ff || !rsp_stall;
   assign fire    = in_valid_ff && advance;
   assign take    = req_valid && !req_stall;

   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   fltg_tag_engine #(
      .TAG_BYTES(TAG_BYTES)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .fire (fire),
      .req  (in_req_ff),
      .rsp  (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff.command    <= cmd_type'(req_command);
         in_req_ff.data_byte  <= req_data_byte;
         in_req_ff.check_byte <= req_check_byte;
      end
      if (fire) begin
         out_rsp_ff <= eng_rsp;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_tag_byte   = out_rsp_ff.tag_byte;
   assign rsp_byte_index = out_rsp_ff.byte_index;
   assign rsp_last       = out_rsp_ff.last;
   assign rsp_mismatch   = out_rsp_ff.mismatch;
   assign rsp_status     = out_rsp_ff.status;

endmodule

>>> rtl/fltg_tag_engine.sv
// ----------------------------------------------------------------------------
// fltg_tag_engine
// Hash, position and mismatch state with the combinational update that
// restarts, absorbs a byte or produces the next tag byte for one request.
// ----------------------------------------------------------------------------
module fltg_tag_engine #(
   parameter int unsigned TAG_BYTES = 2420
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  fltg_pkg::req_type req,
   output fltg_pkg::rsp_type rsp
);
   import fltg_pkg::*;

   localparam logic [POS_WIDTH-1:0] TAG_END  = POS_WIDTH'(TAG_BYTES);
   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(TAG_BYTES - 1);
   localparam logic [POS_WIDTH-1:0] HDR_END  = POS_WIDTH'(HEADER_LEN);

   logic [HASH_WIDTH-1:0] hash_ff, hash_in;
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic                  mis_ff, mis_in;

   logic [HASH_WIDTH-1:0] lcg_hash;
   logic [HASH_WIDTH-1:0] fnv_hash;
   logic                  in_header;
   logic [7:0]            gen_byte;

   assign lcg_hash  = hash_ff * LCG_MUL + LCG_ADD + HASH_WIDTH'(pos_ff);
   assign fnv_hash  = (hash_ff ^ HASH_WIDTH'(req.data_byte)) * FNV_PRIME;
   assign in_header = pos_ff < HDR_END;
   assign gen_byte  = in_header ? HEADER_LETTERS[pos_ff[1:0]]
                                : byte_select(lcg_hash, pos_ff[1:0]);

   always_comb begin
      hash_in        = hash_ff;
      pos_in         = pos_ff;
      mis_in         = mis_ff;
      rsp.tag_byte   = '0;
      rsp.byte_index = '0;
      rsp.last       = 1'b0;
      rsp.status     = 1'b0;
      unique case (req.command)
         CMD_RESTART: begin
            hash_in = FNV_BASIS;
            pos_in  = '0;
            mis_in  = 1'b0;
         end
         CMD_ABSORB: begin
            if (pos_ff != '0) begin
               rsp.status = 1'b1;
            end else begin
               hash_in = fnv_hash;
            end
         end
         CMD_EMIT, CMD_VERIFY: begin
            if (pos_ff >= TAG_END) begin
               rsp.status = 1'b1;
            end else begin
               rsp.tag_byte   = gen_byte;
               rsp.byte_index = pos_ff;
               rsp.last       = (pos_ff == LAST_POS);
               if (!in_header) begin
                  hash_in = lcg_hash;
               end
               if (req.command == CMD_VERIFY && gen_byte != req.check_byte) begin
                  mis_in = 1'b1;
               end
               pos_in = pos_ff + 1'b1;
            end
         end
         default: begin
            rsp.status = 1'b1;
         end
      endcase
      rsp.mismatch = mis_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         pos_ff  <= '0;
         mis_ff  <= 1'b0;
      end else if (fire) begin
         hash_ff <= hash_in;
         pos_ff  <= pos_in;
         mis_ff  <= mis_in;
      end
   end

endmodule

>>> rtl/fltg_checker.sv
// ----------------------------------------------------------------------------
// fltg_checker
// Port-level checks on the tag generator, bound to the top level.
// ----------------------------------------------------------------------------
module fltg_checker #(
   parameter int unsigned TAG_BYTES = 2420
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [7:0]                     rsp_tag_byte,
   input logic [fltg_pkg::POS_WIDTH-1:0] rsp_byte_index,
   input logic                           rsp_last,
   input logic                           rsp_mismatch,
   input logic                           rsp_status
);
   import fltg_pkg::*;

   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(TAG_BYTES - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tag_byte)
         && $stable(rsp_byte_index) && $stable(rsp_last)
         && $stable(rsp_mismatch) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_tag_byte == 8'd0 && rsp_byte_index == '0
         && !rsp_last)
      else $error("ignored request carries tag data");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_byte_index == LAST_POS && !rsp_status)
      else $error("last flag at wrong position");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind fnv_lcg_tag_generator_unit fltg_checker #(.TAG_BYTES(TAG_BYTES)) u_fltg_checker (.*);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fnv/lcg tag generator. Requests are driven with
// random gaps while the response side stalls at random. A per-request
// predictor tracks the hash, tag position and mismatch flag. Every response is
// checked field by field against the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned TAG_LEN     = 2420;
   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned DRAIN_TIME  = 20;

   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_MULT   = 32'd16777619;
   localparam logic [31:0] LCG_MULT   = 32'd1664525;
   localparam logic [31:0] LCG_INC    = 32'd1013904223;
   localparam logic [31:0] SIG_WORD   = "DSIG";

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [1:0]                     req_command;
   logic [7:0]                     req_data_byte;
   logic [7:0]                     req_check_byte;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [7:0]                     rsp_tag_byte;
   logic [fltg_pkg::POS_WIDTH-1:0] rsp_byte_index;
   logic                           rsp_last;
   logic                           rsp_mismatch;
   logic                           rsp_status;

   // predictor state
   logic [31:0]                    fnv_hash;
   logic [fltg_pkg::POS_WIDTH-1:0] tag_count;
   logic                           mismatch_flag;

   fltg_pkg::rsp_type pending_tags[$];
   int unsigned       error_count;
   int unsigned       cycle_count;
   int unsigned       req_sent;
   bit                req_idling;
   bit                rsp_idling;

   fnv_lcg_tag_generator_unit #(
      .TAG_BYTES(TAG_LEN)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .req_check_byte(req_check_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tag_byte  (rsp_tag_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last      (rsp_last),
      .rsp_mismatch  (rsp_mismatch),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      else if (pick < 95) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned req_gap();
      if (!req_idling || $urandom_range(0, 99) < 55) return 0;
      return idle_length();
   endfunction

   function automatic logic [31:0] lcg_advance(input logic [31:0] h,
                                               input logic [fltg_pkg::POS_WIDTH-1:0] p);
      return h * LCG_MULT + LCG_INC + {20'd0, p};
   endfunction

   function automatic logic [7:0] tag_select(input logic [31:0] h,
                                             input logic [fltg_pkg::POS_WIDTH-1:0] p);
      logic [31:0] shifted;
      if (p < 4) return SIG_WORD[31 - 8 * p -: 8];
      shifted = h >> (8 * p[1:0]);
      return shifted[7:0];
   endfunction

   // tag byte that the next emit or verify will produce
   function automatic logic [7:0] upcoming_tag_byte();
      if (tag_count < 4) return tag_select(fnv_hash, tag_count);
      return tag_select(lcg_advance(fnv_hash, tag_count), tag_count);
   endfunction

   function automatic fltg_pkg::rsp_type predict_tag_step(input fltg_pkg::cmd_type cmd,
                                                          input logic [7:0] data,
                                                          input logic [7:0] check);
      fltg_pkg::rsp_type r;
      r = '0;
      case (cmd)
         fltg_pkg::CMD_RESTART: begin
            fnv_hash      = FNV_OFFSET;
            tag_count     = '0;
            mismatch_flag = 1'b0;
         end
         fltg_pkg::CMD_ABSORB: begin
            if (tag_count != 0) r.status = 1'b1;
            else fnv_hash = (fnv_hash ^ {24'd0, data}) * FNV_MULT;
         end
         default: begin
            if (tag_count >= TAG_LEN) begin
               r.status = 1'b1;
            end else begin
               if (tag_count >= 4) fnv_hash = lcg_advance(fnv_hash, tag_count);
               r.tag_byte   = tag_select(fnv_hash, tag_count);
               r.byte_index = tag_count;
               r.last       = (tag_count == TAG_LEN - 1);
               if (cmd == fltg_pkg::CMD_VERIFY && r.tag_byte != check) mismatch_flag = 1'b1;
               tag_count = tag_count + 1'b1;
            end
         end
      endcase
      r.mismatch = mismatch_flag;
      return r;
   endfunction

   // call right after a rising edge
   task automatic send_request(input fltg_pkg::cmd_type cmd, input logic [7:0] data,
                               input logic [7:0] check);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_data_byte  <= data;
      req_check_byte <= check;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      pending_tags.push_back(predict_tag_step(cmd, data, check));
      req_sent++;
      gap = req_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_verify(input int unsigned good_pct);
      logic [7:0] check;
      if ($urandom_range(0, 99) < good_pct) check = upcoming_tag_byte();
      else check = rand_byte();
      send_request(fltg_pkg::CMD_VERIFY, rand_byte(), check);
   endtask

   task automatic test_directed_cases();
      logic [7:0] good;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      send_request(fltg_pkg::CMD_RESTART, 8'hFF, 8'hFF);
      send_request(fltg_pkg::CMD_ABSORB, 8'h00, 8'hFF);
      send_request(fltg_pkg::CMD_ABSORB, 8'hFF, 8'h00);
      send_request(fltg_pkg::CMD_ABSORB, 8'hA5, 8'h5A);
      send_request(fltg_pkg::CMD_ABSORB, 8'h5A, 8'hA5);
      // header letters
      send_request(fltg_pkg::CMD_EMIT, 8'h00, 8'h00);
      send_verify(100);
      good = upcoming_tag_byte();
      send_request(fltg_pkg::CMD_VERIFY, 8'hFF, ~good);
      send_request(fltg_pkg::CMD_EMIT, 8'hFF, 8'hFF);
      // first lcg bytes, one per byte lane
      send_request(fltg_pkg::CMD_EMIT, 8'h00, 8'h00);
      send_verify(100);
      send_request(fltg_pkg::CMD_VERIFY, 8'h00, 8'h00);
      send_request(fltg_pkg::CMD_VERIFY, 8'hFF, 8'hFF);
      // absorb once the tag has started is ignored
      send_request(fltg_pkg::CMD_ABSORB, 8'hFF, 8'h00);
      send_request(fltg_pkg::CMD_ABSORB, 8'h00, 8'hFF);
      send_request(fltg_pkg::CMD_RESTART, 8'h00, 8'h00);
      // tag straight from the offset basis
      send_request(fltg_pkg::CMD_EMIT, 8'h00, 8'h00);
      send_request(fltg_pkg::CMD_EMIT, 8'h00, 8'h00);
      send_request(fltg_pkg::CMD_EMIT, 8'h00, 8'h00);
      send_request(fltg_pkg::CMD_EMIT, 8'h00, 8'h00);
      send_request(fltg_pkg::CMD_EMIT, 8'h00, 8'h00);
      send_request(fltg_pkg::CMD_RESTART, 8'h00, 8'h00);
   endtask

   task automatic test_full_tag(input bit with_idling);
      int unsigned n;
      req_idling = with_idling;
      rsp_idling = with_idling;
      send_request(fltg_pkg::CMD_RESTART, rand_byte(), rand_byte());
      n = $urandom_range(1, 8);
      repeat (n) send_request(fltg_pkg::CMD_ABSORB, rand_byte(), rand_byte());
      repeat (TAG_LEN) begin
         if ($urandom_range(0, 1) == 0) send_request(fltg_pkg::CMD_EMIT, rand_byte(), rand_byte());
         else send_verify(90);
      end
      // tag complete: the emit, verify and absorb below are ignored until the restart
      send_request(fltg_pkg::CMD_EMIT, rand_byte(), rand_byte());
      send_request(fltg_pkg::CMD_VERIFY, rand_byte(), rand_byte());
      send_request(fltg_pkg::CMD_ABSORB, rand_byte(), rand_byte());
      send_request(fltg_pkg::CMD_VERIFY, rand_byte(), rand_byte());
      send_request(fltg_pkg::CMD_RESTART, rand_byte(), rand_byte());
   endtask

   task automatic test_random_sessions(input int unsigned n_items);
      int unsigned stop_at;
      int unsigned n_absorb;
      int unsigned n_tag;
      int unsigned pick;
      stop_at = req_sent + n_items;
      while (req_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         req_idling = (pick >= 15);
         rsp_idling = (pick >= 15);
         if ($urandom_range(0, 99) < 15) begin
            // noise
            repeat ($urandom_range(1, 6))
               send_request(fltg_pkg::cmd_type'($urandom_range(0, 3)), rand_byte(), rand_byte());
         end else begin
            if ($urandom_range(0, 99) < 90)
               send_request(fltg_pkg::CMD_RESTART, rand_byte(), rand_byte());
            n_absorb = $urandom_range(0, 12);
            repeat (n_absorb) send_request(fltg_pkg::CMD_ABSORB, rand_byte(), rand_byte());
            pick = $urandom_range(0, 99);
            if (pick < 20) n_tag = $urandom_range(1, 4);
            else if (pick < 90) n_tag = $urandom_range(5, 40);
            else n_tag = $urandom_range(41, 200);
            repeat (n_tag) begin
               pick = $urandom_range(0, 99);
               if (pick < 8) send_request(fltg_pkg::CMD_ABSORB, rand_byte(), rand_byte());
               else if (pick < 10) send_request(fltg_pkg::CMD_RESTART, rand_byte(), rand_byte());
               else if (pick < 50) send_request(fltg_pkg::CMD_EMIT, rand_byte(), rand_byte());
               else send_verify(75);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side stall pattern
   initial begin : rsp_stall_driver
      int unsigned hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) hold--;
         else if (rsp_idling && $urandom_range(0, 99) < 20) hold = idle_length();
         rsp_stall <= (hold > 0);
      end
   end

   initial begin : tag_checker
      fltg_pkg::rsp_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_tags.size() == 0) begin
               $display("%0t: unexpected response, tag_byte %0h byte_index %0h",
                        $time, rsp_tag_byte, rsp_byte_index);
               error_count++;
            end else begin
               want = pending_tags.pop_front();
               check_field("tag_byte", want.tag_byte, rsp_tag_byte);
               check_field("byte_index", want.byte_index, rsp_byte_index);
               check_field("last", want.last, rsp_last);
               check_field("mismatch", want.mismatch, rsp_mismatch);
               check_field("status", want.status, rsp_status);
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d responses outstanding", $time, pending_tags.size());
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = '0;
      req_data_byte  = '0;
      req_check_byte = '0;
      fnv_hash       = FNV_OFFSET;
      tag_count      = '0;
      mismatch_flag  = 1'b0;
      error_count    = 0;
      req_sent       = 0;
      req_idling     = 1'b0;
      rsp_idling     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_tag(1'b1);
      test_random_sessions(1000);
      req_valid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (DRAIN_TIME) @(posedge clock);
      if (error_count == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/fltg_pkg.sv
rtl/fltg_tag_engine.sv
rtl/fnv_lcg_tag_generator_unit.sv
rtl/fltg_checker.sv
sim/tb_top.sv
